// ----- src/graph_segment_union_find_defines.svh -----
// Assertion macros used by the checker file.
`ifndef GRAPH_SEGMENT_UNION_FIND_DEFINES_SVH
`define GRAPH_SEGMENT_UNION_FIND_DEFINES_SVH

// Same-cycle implication, quiet while reset is held.
`define GSUF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, quiet while reset is held.
`define GSUF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/gsuf_pkg.sv -----
package gsuf_pkg;

    localparam int VERTS        = 4096;
    localparam int LABEL_W      = 12;
    localparam int RANK_W       = 4;
    localparam int SIZE_W       = 13;
    localparam int THR_W        = 25;
    localparam int C_W          = 24;
    localparam int WEIGHT_W     = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int DIV_CNT_W    = 5;

    localparam logic [C_W-1:0]       C_RESET     = 24'd76800;
    localparam logic [SIZE_W-1:0]    COUNT_RESET = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VCOUNT    = 2'd1;

    localparam logic [1:0] OP_EDGE  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_ORDER = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [LABEL_W-1:0] parent;
        logic [RANK_W-1:0]  rank;
        logic [SIZE_W-1:0]  size;
        logic [THR_W-1:0]   thr;
    } entry_t;

    typedef struct packed {
        logic              start;
        logic [C_W-1:0]    dividend;
        logic [SIZE_W-1:0] divisor;
    } div_req_t;

endpackage

// ----- src/gsuf_div.sv -----
module gsuf_div
    import gsuf_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  div_req_t       req,
    output logic           done,
    output logic [C_W-1:0] quotient
);

    logic [SIZE_W-1:0]    rem_reg;
    logic [C_W-1:0]       quo_reg;
    logic [SIZE_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [SIZE_W:0]      shifted;
    logic [SIZE_W:0]      diff;

    // one quotient bit per cycle, restoring
    assign shifted = {rem_reg, quo_reg[C_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
            dvs_reg  <= (req.divisor == '0) ? SIZE_W'(1) : req.divisor;
        end else if (busy_reg) begin
            if (!diff[SIZE_W]) begin
                rem_reg <= diff[SIZE_W-1:0];
                quo_reg <= {quo_reg[C_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[SIZE_W-1:0];
                quo_reg <= {quo_reg[C_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(C_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/graph_segment_union_find.sv -----
// Disjoint-set graph segmentation engine. One word at a time: s_ready is low while a
// word is being worked on. After reset, and for every clear word, a clearing pass
// writes all 4096 table entries, one per cycle, and a clear word then reports. A query
// reads each table entry on the way from vertex_a to the root, writes back, and reports;
// an edge walks vertex_a, vertex_b and vertex_a again, reading each entry visited and
// doing one write-back per walk (path compression keeps chains short), then reports.
// A merge adds a child write, a bit-serial divide of c by the merged set size into a
// 24-bit quotient, and a root write. The set table has one read and one write port.
// Results wait in an output register; config writes are always accepted.
module graph_segment_union_find
    import gsuf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_operation,
    input  logic [LABEL_W-1:0]   s_vertex_a,
    input  logic [LABEL_W-1:0]   s_vertex_b,
    input  logic [WEIGHT_W-1:0]  s_weight,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [LABEL_W-1:0]   m_root_label,
    output logic [SIZE_W-1:0]    m_component_size,
    output logic                 m_merged,
    output logic [1:0]           m_status,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [C_W-1:0]       cfg_data
);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_CHK    = 4'd3;
    localparam logic [3:0] S_WB     = 4'd4;
    localparam logic [3:0] S_WCHILD = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_WROOT  = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    localparam logic [1:0] PH_A1 = 2'd0;
    localparam logic [1:0] PH_B  = 2'd1;
    localparam logic [1:0] PH_A2 = 2'd2;
    localparam logic [1:0] PH_Q  = 2'd3;

    entry_t mem [VERTS];

    logic [3:0]          state_reg;
    logic [1:0]          phase_reg;
    logic [C_W-1:0]      c_reg;
    logic [SIZE_W-1:0]   vcount_reg;
    logic [WEIGHT_W-1:0] last_w_reg;
    logic [C_W-1:0]      clr_c_reg;
    logic [LABEL_W-1:0]  clr_idx_reg;
    logic                clr_report_reg;

    logic [LABEL_W-1:0]  a_reg, b_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic [LABEL_W-1:0]  cur_reg, v_reg, root_reg, ra_reg;
    logic                first_reg;
    entry_t              rdata_reg, ventry_reg, rentry_reg, ra_entry_reg;
    logic [LABEL_W-1:0]  child_reg, nr_reg;
    entry_t              child_entry_reg, nr_entry_reg;
    logic                merged_reg;

    logic [LABEL_W-1:0]  res_root_reg;
    logic [SIZE_W-1:0]   res_size_reg;
    logic                res_merged_reg;
    logic [1:0]          res_status_reg;
    logic                m_valid_reg;

    logic                mem_we;
    logic [LABEL_W-1:0]  mem_wa;
    entry_t              mem_wd;
    div_req_t            div_req;
    logic                div_done;
    logic [C_W-1:0]      div_q;
    logic [SIZE_W-1:0]   n_eff;
    logic                a_out, b_out;
    logic                s_fire;
    logic                join_ok;
    logic [SIZE_W-1:0]   size_sum;

    assign n_eff  = (vcount_reg > SIZE_W'(VERTS)) ? SIZE_W'(VERTS) : vcount_reg;
    assign a_out  = {1'b0, s_vertex_a} >= n_eff;
    assign b_out  = {1'b0, s_vertex_b} >= n_eff;
    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign join_ok = (ra_reg != root_reg)
                   && ({{(THR_W-WEIGHT_W){1'b0}}, w_reg} <= ra_entry_reg.thr)
                   && ({{(THR_W-WEIGHT_W){1'b0}}, w_reg} <= rentry_reg.thr);
    assign size_sum = ra_entry_reg.size + rentry_reg.size;

    gsuf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        div_req.start    = (state_reg == S_WB) && (phase_reg == PH_B) && join_ok;
        div_req.dividend = c_reg;
        div_req.divisor  = size_sum;
    end

    // single write port
    always_comb begin
        mem_we = 1'b0;
        mem_wa = v_reg;
        mem_wd = ventry_reg;
        case (state_reg)
            S_CLR: begin
                mem_we        = 1'b1;
                mem_wa        = clr_idx_reg;
                mem_wd.parent = clr_idx_reg;
                mem_wd.rank   = '0;
                mem_wd.size   = SIZE_W'(1);
                mem_wd.thr    = {1'b0, clr_c_reg};
            end
            S_WB: begin
                mem_we        = 1'b1;
                mem_wa        = v_reg;
                mem_wd        = ventry_reg;
                mem_wd.parent = root_reg;
            end
            S_WCHILD: begin
                mem_we        = 1'b1;
                mem_wa        = child_reg;
                mem_wd        = child_entry_reg;
                mem_wd.parent = nr_reg;
            end
            S_WROOT: begin
                mem_we     = 1'b1;
                mem_wa     = nr_reg;
                mem_wd     = nr_entry_reg;
                mem_wd.thr = THR_W'(w_reg) + THR_W'(div_q);
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[cur_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg      <= C_RESET;
            vcount_reg <= COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_THRESHOLD) begin
                c_reg <= cfg_data;
            end else if (cfg_index == REG_VCOUNT) begin
                vcount_reg <= cfg_data[SIZE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            phase_reg      <= PH_A1;
            clr_idx_reg    <= '0;
            clr_c_reg      <= C_RESET;
            clr_report_reg <= 1'b0;
            last_w_reg     <= '0;
            m_valid_reg    <= 1'b0;
            cur_reg        <= '0;
        end else begin
            // drop the word once taken, unless a new one is loaded this cycle
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR: begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == LABEL_W'(VERTS - 1)) begin
                        state_reg <= clr_report_reg ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        a_reg          <= s_vertex_a;
                        b_reg          <= s_vertex_b;
                        w_reg          <= s_weight;
                        cur_reg        <= s_vertex_a;
                        v_reg          <= s_vertex_a;
                        first_reg      <= 1'b1;
                        merged_reg     <= 1'b0;
                        res_root_reg   <= '0;
                        res_size_reg   <= '0;
                        res_merged_reg <= 1'b0;
                        case (s_operation)
                            OP_CLEAR: begin
                                res_status_reg <= STATUS_OK;
                                clr_idx_reg    <= '0;
                                clr_c_reg      <= c_reg;
                                clr_report_reg <= 1'b1;
                                last_w_reg     <= '0;
                                state_reg      <= S_CLR;
                            end
                            OP_QUERY: begin
                                phase_reg <= PH_Q;
                                if (a_out) begin
                                    res_status_reg <= STATUS_RANGE;
                                    state_reg      <= S_OUT;
                                end else begin
                                    res_status_reg <= STATUS_OK;
                                    state_reg      <= S_RD;
                                end
                            end
                            OP_EDGE: begin
                                phase_reg <= PH_A1;
                                if (a_out || b_out) begin
                                    res_status_reg <= STATUS_RANGE;
                                    state_reg      <= S_OUT;
                                end else begin
                                    res_status_reg <= STATUS_OK;
                                    state_reg      <= S_RD;
                                end
                            end
                            default: begin
                                res_status_reg <= STATUS_OK;
                                state_reg      <= S_OUT;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    first_reg <= 1'b0;
                    if (first_reg) begin
                        ventry_reg <= rdata_reg;
                    end
                    if (rdata_reg.parent == cur_reg) begin
                        root_reg   <= cur_reg;
                        rentry_reg <= rdata_reg;
                        state_reg  <= S_WB;
                    end else begin
                        cur_reg   <= rdata_reg.parent;
                        state_reg <= S_RD;
                    end
                end
                S_WB: begin
                    case (phase_reg)
                        PH_Q, PH_A2: begin
                            res_root_reg   <= root_reg;
                            res_size_reg   <= rentry_reg.size;
                            res_merged_reg <= merged_reg;
                            state_reg      <= S_OUT;
                        end
                        PH_A1: begin
                            ra_reg       <= root_reg;
                            ra_entry_reg <= rentry_reg;
                            if (w_reg < last_w_reg) begin
                                res_root_reg   <= root_reg;
                                res_size_reg   <= rentry_reg.size;
                                res_status_reg <= STATUS_ORDER;
                                state_reg      <= S_OUT;
                            end else begin
                                phase_reg <= PH_B;
                                cur_reg   <= b_reg;
                                v_reg     <= b_reg;
                                first_reg <= 1'b1;
                                state_reg <= S_RD;
                            end
                        end
                        default: begin
                            last_w_reg <= w_reg;
                            phase_reg  <= PH_A2;
                            cur_reg    <= a_reg;
                            v_reg      <= a_reg;
                            first_reg  <= 1'b1;
                            if (join_ok) begin
                                merged_reg <= 1'b1;
                                state_reg  <= S_WCHILD;
                                // larger rank wins; tie goes to vertex_b's root
                                if (ra_entry_reg.rank > rentry_reg.rank) begin
                                    nr_reg          <= ra_reg;
                                    nr_entry_reg    <= '{parent: ra_entry_reg.parent,
                                                         rank:   ra_entry_reg.rank,
                                                         size:   size_sum,
                                                         thr:    ra_entry_reg.thr};
                                    child_reg       <= root_reg;
                                    child_entry_reg <= rentry_reg;
                                end else begin
                                    nr_reg          <= root_reg;
                                    nr_entry_reg    <= '{parent: rentry_reg.parent,
                                                         rank:   (ra_entry_reg.rank ==
                                                                  rentry_reg.rank) ?
                                                                 rentry_reg.rank + 1'b1 :
                                                                 rentry_reg.rank,
                                                         size:   size_sum,
                                                         thr:    rentry_reg.thr};
                                    child_reg       <= ra_reg;
                                    child_entry_reg <= ra_entry_reg;
                                end
                            end else begin
                                state_reg <= S_RD;
                            end
                        end
                    endcase
                end
                S_WCHILD: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        state_reg <= S_WROOT;
                    end
                end
                S_WROOT: begin
                    state_reg <= S_RD;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_root_label     <= res_root_reg;
                        m_component_size <= res_size_reg;
                        m_merged         <= res_merged_reg;
                        m_status         <= res_status_reg;
                        m_valid_reg      <= 1'b1;
                        clr_report_reg   <= 1'b0;
                        state_reg        <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- src/gsuf_checker.sv -----
`include "graph_segment_union_find_defines.svh"

module gsuf_checker
    import gsuf_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [LABEL_W-1:0]   m_root_label,
    input logic [SIZE_W-1:0]    m_component_size,
    input logic                 m_merged,
    input logic [1:0]           m_status
);

    `GSUF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `GSUF_ASSERT_NEXT(a_busy_after_word, aclk, aresetn, s_valid && s_ready, !s_ready)
    `GSUF_ASSERT_NOW(a_range_zero, aclk, aresetn, m_valid && (m_status == STATUS_RANGE), (m_root_label == '0) && (m_component_size == '0) && !m_merged)
    `GSUF_ASSERT_NOW(a_merge_ok, aclk, aresetn, m_valid && m_merged, (m_status == STATUS_OK) && (m_component_size > SIZE_W'(1)))

endmodule

bind graph_segment_union_find gsuf_checker u_gsuf_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_root_label     (m_root_label),
    .m_component_size (m_component_size),
    .m_merged         (m_merged),
    .m_status         (m_status)
);
